// ===== design/ppm_pkg.sv =====
// ----------------------------------------------------------------------------
// ppm_pkg
// Shared constants, types and helpers of the PPM encoder with channel scaling.
// ----------------------------------------------------------------------------
package ppm_pkg;

  localparam int CHAN_COUNT   = 8;
  localparam int SLOT_W       = $clog2(CHAN_COUNT + 1);
  localparam int IDX_W        = (CHAN_COUNT > 1) ? $clog2(CHAN_COUNT) : 1;

  localparam int CH_W         = 3;
  localparam int SAMPLE_W     = 10;
  localparam int TRIM_W       = 8;
  localparam int WIDTH_W      = 12;
  localparam int BASE_W       = WIDTH_W + 1;
  localparam int DIFF_W       = SAMPLE_W + 1;
  localparam int OUT_SLOT_W   = 4;
  localparam int CNT_W        = 16;
  localparam int TPU_W        = 5;
  localparam int MASK_W       = 8;

  localparam int PROD_A_W     = BASE_W + SAMPLE_W;
  localparam int PROD_B_W     = DIFF_W + BASE_W;
  localparam int NUM_W        = PROD_B_W;
  localparam int DIV_STEPS    = WIDTH_W;
  localparam int DVS_W        = SAMPLE_W + WIDTH_W - 1;
  localparam int STEP_W       = $clog2(DIV_STEPS);

  localparam int QUEUE_DEPTH  = 2;
  localparam int QPTR_W       = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W       = $clog2(QUEUE_DEPTH + 1);

  localparam int CFG_IDX_W    = 3;
  localparam int CFG_DATA_W   = 12;

  localparam logic [WIDTH_W-1:0] WIDTH_MAX = '1;
  localparam logic [CNT_W-1:0]   CNT_MAX   = '1;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MIN_WIDTH    = 3'd0,
    CFG_TRAVERSAL    = 3'd1,
    CFG_REVERSE_MASK = 3'd2,
    CFG_GAP_WIDTH    = 3'd3,
    CFG_SYNC_WIDTH   = 3'd4,
    CFG_TICKS_PER_US = 3'd5
  } cfg_idx_t;

  typedef struct packed {
    logic [WIDTH_W-1:0] min_width;
    logic [WIDTH_W-1:0] traversal;
    logic [MASK_W-1:0]  reverse_mask;
    logic [WIDTH_W-1:0] gap_width;
    logic [WIDTH_W-1:0] sync_width;
    logic [TPU_W-1:0]   ticks_per_us;
  } cfg_t;

  // Classified item as it travels from the front part to the back part.
  typedef struct packed {
    logic                is_tick;
    logic [CH_W-1:0]     channel;
    logic [BASE_W-1:0]   base;
    logic [SAMPLE_W-1:0] rng_abs;
    logic                rng_zero;
    logic [DIFF_W-1:0]   dval;
  } rec_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_MUL,
    BK_SUM,
    BK_DIV,
    BK_DONE
  } back_state_t;

  function automatic logic [CNT_W-1:0] us_to_ticks(input logic [WIDTH_W-1:0] us,
                                                   input logic [TPU_W-1:0]   tpu);
    logic [WIDTH_W+TPU_W-1:0] p;
    p = (WIDTH_W+TPU_W)'(us) * (WIDTH_W+TPU_W)'(tpu);
    if (p > (WIDTH_W+TPU_W)'(CNT_MAX)) begin
      return CNT_MAX;
    end
    return p[CNT_W-1:0];
  endfunction

endpackage

// ===== design/ppm_if.sv =====
// ----------------------------------------------------------------------------
// ppm_in_if / ppm_out_if
// Valid/ready channels of the PPM encoder: command items in, results out.
// ----------------------------------------------------------------------------
interface ppm_in_if;
  import ppm_pkg::*;

  logic                valid;
  logic                ready;
  logic                cmd;
  logic [CH_W-1:0]     channel;
  logic [SAMPLE_W-1:0] sample;
  logic [SAMPLE_W-1:0] cal_lower;
  logic [SAMPLE_W-1:0] cal_upper;
  logic [TRIM_W-1:0]   trim;

  modport source (output valid, cmd, channel, sample, cal_lower, cal_upper, trim,
                  input ready);
  modport sink   (input valid, cmd, channel, sample, cal_lower, cal_upper, trim,
                  output ready);
endinterface

interface ppm_out_if;
  import ppm_pkg::*;

  logic                  valid;
  logic                  ready;
  logic                  pin_level;
  logic [OUT_SLOT_W-1:0] slot;
  logic [WIDTH_W-1:0]    width_stored;

  modport source (output valid, pin_level, slot, width_stored, input ready);
  modport sink   (input valid, pin_level, slot, width_stored, output ready);
endinterface

// ===== design/ppm_encoder_with_channel_scaling.sv =====
// ----------------------------------------------------------------------------
// ppm_encoder_with_channel_scaling
// RC PPM pulse train encoder with per-channel stick scaling and trim.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Handshake        Carries
//  in_ch     in         valid/ready      cmd, channel, sample, cal_lower,
//                                        cal_upper, trim
//  out_ch    out        valid/ready      pin_level, slot, width_stored
//  cfg_*     in         cfg_we only      cfg_index, cfg_wdata (12 bits)
//
//  Ticks are handled in the back part's idle state, one per clock while out_ch is free.
//  A sample item passes through the back part as take, multiply, sum, the
//  one-bit-a-cycle divider (12 steps and a hand-over) when a division is
//  needed, then write-back.
//  Reset is synchronous; all control state and the width table clear at once.
//  A stalled out_ch holds its item; the two-entry queue fills and then drops
//  in_ch.ready, so the front and back stall independently.
//
// ----------------------------------------------------------------------------
module ppm_encoder_with_channel_scaling (
  input  logic                             clk,
  input  logic                             rst_n,
  ppm_in_if.sink                           in_ch,
  ppm_out_if.source                        out_ch,
  input  logic                             cfg_we,
  input  logic [ppm_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [ppm_pkg::CFG_DATA_W-1:0]   cfg_wdata
);
  import ppm_pkg::*;

  cfg_t cfg_r, cfg_nxt;
  logic push;
  logic q_full;
  logic q_valid;
  logic q_pop;
  rec_t rec_in;
  rec_t rec_out;

  // Configuration registers: write only, one register per edge.
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_index)
        CFG_MIN_WIDTH:    cfg_nxt.min_width    = cfg_wdata[WIDTH_W-1:0];
        CFG_TRAVERSAL:    cfg_nxt.traversal    = cfg_wdata[WIDTH_W-1:0];
        CFG_REVERSE_MASK: cfg_nxt.reverse_mask = cfg_wdata[MASK_W-1:0];
        CFG_GAP_WIDTH:    cfg_nxt.gap_width    = cfg_wdata[WIDTH_W-1:0];
        CFG_SYNC_WIDTH:   cfg_nxt.sync_width   = cfg_wdata[WIDTH_W-1:0];
        CFG_TICKS_PER_US: cfg_nxt.ticks_per_us = cfg_wdata[TPU_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.min_width    <= WIDTH_W'(1000);
      cfg_r.traversal    <= WIDTH_W'(1000);
      cfg_r.reverse_mask <= '0;
      cfg_r.gap_width    <= WIDTH_W'(300);
      cfg_r.sync_width   <= WIDTH_W'(4000);
      cfg_r.ticks_per_us <= TPU_W'(1);
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // Front: accept and classify, prepare the scaling operands.
  ppm_front u_front (
    .in_ch  (in_ch),
    .cfg    (cfg_r),
    .q_full (q_full),
    .push   (push),
    .rec    (rec_in)
  );

  // Decouple front and back.
  ppm_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .rec_in  (rec_in),
    .full    (q_full),
    .pop     (q_pop),
    .q_valid (q_valid),
    .rec_out (rec_out)
  );

  // Back: timer, slot sequencing, scaling arithmetic and result register.
  ppm_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg     (cfg_r),
    .q_valid (q_valid),
    .q_rec   (rec_out),
    .q_pop   (q_pop),
    .out_ch  (out_ch)
  );

endmodule

// ===== design/ppm_front.sv =====
// ----------------------------------------------------------------------------
// ppm_front
// Accepts items, classifies them and prepares the scaling operands.
// ----------------------------------------------------------------------------
module ppm_front (
  ppm_in_if.sink          in_ch,
  input  ppm_pkg::cfg_t   cfg,
  input  logic            q_full,
  output logic            push,
  output ppm_pkg::rec_t   rec
);
  import ppm_pkg::*;

  logic signed [DIFF_W-1:0] rng;
  logic signed [DIFF_W-1:0] dsel;
  logic signed [DIFF_W-1:0] rng_neg;
  logic signed [DIFF_W-1:0] dsel_neg;
  logic                     rev;

  assign in_ch.ready = !q_full;
  assign push        = in_ch.valid && !q_full;

  always_comb begin
    rev      = cfg.reverse_mask[in_ch.channel];
    rng      = $signed({1'b0, in_ch.cal_upper}) - $signed({1'b0, in_ch.cal_lower});
    dsel     = rev ? ($signed({1'b0, in_ch.cal_upper}) - $signed({1'b0, in_ch.sample}))
                   : ($signed({1'b0, in_ch.sample}) - $signed({1'b0, in_ch.cal_lower}));
    rng_neg  = -rng;
    dsel_neg = -dsel;

    rec.is_tick  = in_ch.cmd;
    rec.channel  = in_ch.channel;
    rec.base     = BASE_W'(cfg.min_width) + BASE_W'(in_ch.trim);
    rec.rng_zero = (in_ch.cal_upper == in_ch.cal_lower);
    // Fold a negative range into the numerator so the divider sees |range|.
    rec.rng_abs  = rng[DIFF_W-1] ? rng_neg[SAMPLE_W-1:0] : rng[SAMPLE_W-1:0];
    rec.dval     = rng[DIFF_W-1] ? dsel_neg : dsel;
  end

endmodule

// ===== design/ppm_queue.sv =====
// ----------------------------------------------------------------------------
// ppm_queue
// Short FIFO of classified items between the front and back parts.
// ----------------------------------------------------------------------------
module ppm_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  ppm_pkg::rec_t rec_in,
  output logic          full,
  input  logic          pop,
  output logic          q_valid,
  output ppm_pkg::rec_t rec_out
);
  import ppm_pkg::*;

  rec_t              mem_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] count_r, count_nxt;

  assign full    = (count_r == QCNT_W'(QUEUE_DEPTH));
  assign q_valid = (count_r != '0);
  assign rec_out = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= rec_in;
    end
  end

endmodule

// ===== design/ppm_div.sv =====
// ----------------------------------------------------------------------------
// ppm_div
// Restoring divider, one quotient bit per cycle; quotient known to fit.
// ----------------------------------------------------------------------------
module ppm_div (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  logic [ppm_pkg::NUM_W-1:0]    num,
  input  logic [ppm_pkg::SAMPLE_W-1:0] den,
  output logic                         done,
  output logic [ppm_pkg::WIDTH_W-1:0]  quo
);
  import ppm_pkg::*;

  logic [NUM_W-1:0]   rem_r, rem_nxt;
  logic [DVS_W-1:0]   dvs_r, dvs_nxt;
  logic [WIDTH_W-1:0] quo_r, quo_nxt;
  logic [STEP_W-1:0]  step_r, step_nxt;
  logic               run_r, run_nxt;
  logic               done_r, done_nxt;
  logic               ge;

  assign done = done_r;
  assign quo  = quo_r;
  assign ge   = (rem_r >= NUM_W'(dvs_r));

  always_comb begin
    rem_nxt  = rem_r;
    dvs_nxt  = dvs_r;
    quo_nxt  = quo_r;
    step_nxt = step_r;
    run_nxt  = run_r;
    done_nxt = 1'b0;
    if (start) begin
      rem_nxt  = num;
      dvs_nxt  = {den, {(WIDTH_W-1){1'b0}}};
      step_nxt = '0;
      run_nxt  = 1'b1;
    end else if (run_r) begin
      if (ge) begin
        rem_nxt = rem_r - NUM_W'(dvs_r);
      end
      quo_nxt  = {quo_r[WIDTH_W-2:0], ge};
      dvs_nxt  = dvs_r >> 1;
      step_nxt = step_r + 1'b1;
      if (step_r == STEP_W'(DIV_STEPS - 1)) begin
        run_nxt  = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      run_r  <= run_nxt;
      done_r <= done_nxt;
      step_r <= step_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
    quo_r <= quo_nxt;
  end

endmodule

// ===== design/ppm_back.sv =====
// ----------------------------------------------------------------------------
// ppm_back
// Executes items in order: ticks directly from idle, samples through a multiply,
// sum and, if needed, divide sequence. Holds the width table and the result.
// ----------------------------------------------------------------------------
module ppm_back (
  input  logic          clk,
  input  logic          rst_n,
  input  ppm_pkg::cfg_t cfg,
  input  logic          q_valid,
  input  ppm_pkg::rec_t q_rec,
  output logic          q_pop,
  ppm_out_if.source     out_ch
);
  import ppm_pkg::*;

  back_state_t              state_r, state_nxt;
  rec_t                     smp_r, smp_nxt;
  logic [PROD_A_W-1:0]      prod_a_r, prod_a_nxt;
  logic signed [PROD_B_W-1:0] prod_b_r, prod_b_nxt;
  logic [WIDTH_W-1:0]       res_r, res_nxt;
  logic [WIDTH_W-1:0]       table_r [CHAN_COUNT];
  logic [WIDTH_W-1:0]       table_nxt [CHAN_COUNT];
  logic [SLOT_W-1:0]        slot_r, slot_nxt;
  logic [CNT_W-1:0]         tick_r, tick_nxt;
  logic [CNT_W-1:0]         cmp_r, cmp_nxt;
  logic                     pin_r, pin_nxt;
  logic                     out_valid_r, out_valid_nxt;
  logic                     out_pin_r, out_pin_nxt;
  logic [OUT_SLOT_W-1:0]    out_slot_r, out_slot_nxt;
  logic [WIDTH_W-1:0]       out_width_r, out_width_nxt;

  logic                     out_free;
  logic signed [NUM_W:0]    num_s;
  logic [NUM_W-1:0]         num_u;
  logic                     num_pos;
  logic                     over;
  logic [WIDTH_W-1:0]       base_sat;
  logic                     sum_direct;
  logic [WIDTH_W-1:0]       sum_res;
  logic                     div_start;
  logic                     div_done;
  logic [WIDTH_W-1:0]       div_quo;

  logic [CNT_W-1:0]         cnt_inc;
  logic                     match;
  logic [SLOT_W-1:0]        slot_inc;
  logic [WIDTH_W-1:0]       slot_w;

  ppm_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (num_u),
    .den   (smp_r.rng_abs),
    .done  (div_done),
    .quo   (div_quo)
  );

  assign out_ch.valid        = out_valid_r;
  assign out_ch.pin_level    = out_pin_r;
  assign out_ch.slot         = out_slot_r;
  assign out_ch.width_stored = out_width_r;
  assign out_free            = !out_valid_r || out_ch.ready;

  // Sample arithmetic on the registered products.
  always_comb begin
    num_s      = $signed({2'b00, prod_a_r}) + $signed({prod_b_r[PROD_B_W-1], prod_b_r});
    num_u      = num_s[NUM_W-1:0];
    num_pos    = !num_s[NUM_W] && (num_s != '0);
    over       = num_u >= NUM_W'({smp_r.rng_abs, {WIDTH_W{1'b0}}});
    base_sat   = (smp_r.base > BASE_W'(WIDTH_MAX)) ? WIDTH_MAX : smp_r.base[WIDTH_W-1:0];
    sum_direct = smp_r.rng_zero || !num_pos || over;
    if (smp_r.rng_zero) begin
      sum_res = base_sat;
    end else if (!num_pos) begin
      sum_res = '0;
    end else begin
      sum_res = WIDTH_MAX;
    end
  end

  // Timer step for a tick item.
  always_comb begin
    cnt_inc  = tick_r + 1'b1;
    match    = (cnt_inc >= cmp_r);
    slot_inc = (slot_r == SLOT_W'(CHAN_COUNT)) ? '0 : slot_r + 1'b1;
    slot_w   = (slot_inc < SLOT_W'(CHAN_COUNT)) ? table_r[IDX_W'(slot_inc)]
                                               : cfg.sync_width;
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      BK_IDLE: begin
        if (q_valid && !q_rec.is_tick) begin
          state_nxt = BK_MUL;
        end
      end
      BK_MUL:  state_nxt = BK_SUM;
      BK_SUM:  state_nxt = sum_direct ? BK_DONE : BK_DIV;
      BK_DIV: begin
        if (div_done) begin
          state_nxt = BK_DONE;
        end
      end
      BK_DONE: begin
        if (out_free) begin
          state_nxt = BK_IDLE;
        end
      end
      default: state_nxt = BK_IDLE;
    endcase
  end

  always_comb begin
    smp_nxt       = smp_r;
    prod_a_nxt    = prod_a_r;
    prod_b_nxt    = prod_b_r;
    res_nxt       = res_r;
    table_nxt     = table_r;
    slot_nxt      = slot_r;
    tick_nxt      = tick_r;
    cmp_nxt       = cmp_r;
    pin_nxt       = pin_r;
    out_valid_nxt = out_valid_r;
    out_pin_nxt   = out_pin_r;
    out_slot_nxt  = out_slot_r;
    out_width_nxt = out_width_r;
    q_pop         = 1'b0;
    div_start     = 1'b0;

    if (out_valid_r && out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      BK_IDLE: begin
        if (q_valid) begin
          if (q_rec.is_tick) begin
            if (out_free) begin
              q_pop = 1'b1;
              if (match) begin
                tick_nxt = '0;
                pin_nxt  = !pin_r;
                if (!pin_r) begin
                  slot_nxt = slot_inc;
                  cmp_nxt  = us_to_ticks(slot_w, cfg.ticks_per_us);
                end else begin
                  cmp_nxt  = us_to_ticks(cfg.gap_width, cfg.ticks_per_us);
                end
              end else begin
                tick_nxt = cnt_inc;
              end
              out_valid_nxt = 1'b1;
              out_pin_nxt   = pin_nxt;
              out_slot_nxt  = OUT_SLOT_W'(slot_nxt);
              out_width_nxt = '0;
            end
          end else begin
            q_pop   = 1'b1;
            smp_nxt = q_rec;
          end
        end
      end
      BK_MUL: begin
        prod_a_nxt = PROD_A_W'(smp_r.base) * PROD_A_W'(smp_r.rng_abs);
        prod_b_nxt = PROD_B_W'($signed(smp_r.dval)) *
                     PROD_B_W'($signed({1'b0, cfg.traversal}));
      end
      BK_SUM: begin
        if (sum_direct) begin
          res_nxt = sum_res;
        end else begin
          div_start = 1'b1;
        end
      end
      BK_DIV: begin
        if (div_done) begin
          res_nxt = div_quo;
        end
      end
      BK_DONE: begin
        if (out_free) begin
          if (32'(smp_r.channel) < CHAN_COUNT) begin
            table_nxt[IDX_W'(smp_r.channel)] = res_r;
          end
          out_valid_nxt = 1'b1;
          out_pin_nxt   = pin_r;
          out_slot_nxt  = OUT_SLOT_W'(slot_r);
          out_width_nxt = res_r;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= BK_IDLE;
      slot_r      <= SLOT_W'(CHAN_COUNT);
      tick_r      <= '0;
      cmp_r       <= '0;
      pin_r       <= 1'b0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < CHAN_COUNT; i++) begin
        table_r[i] <= '0;
      end
    end else begin
      state_r     <= state_nxt;
      slot_r      <= slot_nxt;
      tick_r      <= tick_nxt;
      cmp_r       <= cmp_nxt;
      pin_r       <= pin_nxt;
      out_valid_r <= out_valid_nxt;
      table_r     <= table_nxt;
    end
  end

  always_ff @(posedge clk) begin
    smp_r       <= smp_nxt;
    prod_a_r    <= prod_a_nxt;
    prod_b_r    <= prod_b_nxt;
    res_r       <= res_nxt;
    out_pin_r   <= out_pin_nxt;
    out_slot_r  <= out_slot_nxt;
    out_width_r <= out_width_nxt;
  end

endmodule

// ===== design/ppm_checker.sv =====
// ----------------------------------------------------------------------------
// ppm_checker
// Port-level checks on the result channel of the PPM encoder.
// ----------------------------------------------------------------------------
module ppm_checker (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             out_valid,
  input logic                             out_ready,
  input logic                             out_pin_level,
  input logic [ppm_pkg::OUT_SLOT_W-1:0]   out_slot,
  input logic [ppm_pkg::WIDTH_W-1:0]      out_width_stored
);
  import ppm_pkg::*;

  // Hold a stalled item unchanged.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_pin_level) &&
                                $stable(out_slot) && $stable(out_width_stored))
    else $error("stalled result changed");

  // Drop valid only once the item is taken.
  a_out_drop: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(out_valid) |-> $past(out_ready))
    else $error("result withdrawn before it was taken");

  a_slot_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> 32'(out_slot) <= CHAN_COUNT)
    else $error("slot beyond sync slot");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind ppm_encoder_with_channel_scaling ppm_checker u_ppm_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .out_valid        (out_ch.valid),
  .out_ready        (out_ch.ready),
  .out_pin_level    (out_ch.pin_level),
  .out_slot         (out_ch.slot),
  .out_width_stored (out_ch.width_stored)
);
